// ----- rtl/tcfs_pkg.sv -----
// tcfs_pkg: shared widths, register indexes, phase codes and the
// configuration bundle for the three-color fade sequencer
// no dependencies
package tcfs_pkg;

    localparam int COLOR_W  = 24;
    localparam int TICK_W   = 16;
    localparam int BRT_W    = 8;
    localparam int SLOT_W   = 2;
    localparam int ELAPSE_W = 17;
    localparam int ACC_W    = 26;
    localparam int STEPV_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [BRT_W-1:0] BRT_RESET = 8'd100;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_COLOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_MS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRT_ONE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRT_TWO      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_TWO     = 3'd7;

    localparam logic [1:0] PH_FADE_IN  = 2'd0;
    localparam logic [1:0] PH_HOLD     = 2'd1;
    localparam logic [1:0] PH_FADE_OUT = 2'd2;

    localparam logic [SLOT_W-1:0] SLOT_FIRST  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_SECOND = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_LAST   = 2'd2;

    typedef struct packed {
        logic [COLOR_W-1:0] first_color;
        logic [COLOR_W-1:0] second_color;
        logic [COLOR_W-1:0] third_color;
        logic [TICK_W-1:0]  hold_ms;
        logic [TICK_W-1:0]  fade_ms;
        logic [BRT_W-1:0]   brightness_type_one;
        logic [BRT_W-1:0]   brightness_type_two;
        logic               device_is_type_two;
    } cfg_t;

endpackage

// ----- rtl/three_color_fade_sequencer_top.sv -----
// three_color_fade_sequencer_top: tick sequencer with fade, hold and color cycling
// depends on tcfs_pkg, tcfs_regs, tcfs_div
// a tick with running low is handled in its accept cycle; any other tick takes the accept
// cycle, then one sequencer step a cycle, up to five steps
// the tick that starts a sequence with a nonzero fade first waits for the serial
// step divider; a waiting output word stalls the step that would emit
// reset (rst_n, async, low) idles the block and loads the register defaults
module three_color_fade_sequencer_top
    import tcfs_pkg::*;
#(
    parameter int STEP_TICKS = 50
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  running,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COLOR_W-1:0]    shown_color,
    output logic [BRT_W-1:0]      shown_brightness,
    output logic [SLOT_W-1:0]     color_slot,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;

    localparam logic [2:0] LAST_GUARD = 3'd4;

    localparam logic [TICK_W-1:0]   ST_TICK    = TICK_W'(STEP_TICKS);
    localparam logic [ELAPSE_W-1:0] ST_ELAPSE  = ELAPSE_W'(STEP_TICKS);
    localparam logic [TICK_W-1:0]   FIRST_TICK = (STEP_TICKS > 1) ? TICK_W'(1) : '0;

    localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};

    cfg_t cfg;

    logic               div_start;
    logic               div_done;
    logic [STEPV_W-1:0] div_quot;
    logic [BRT_W-1:0]   target;

    logic [1:0]              state_reg, state_next;
    logic                    active_reg, active_next;
    logic [1:0]              phase_reg, phase_next;
    logic [SLOT_W-1:0]       pos_reg, pos_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic [ELAPSE_W-1:0]     elapsed_reg, elapsed_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [STEPV_W-1:0]      step_reg, step_next;
    logic [2:0]              guard_reg, guard_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]      out_color_reg, out_color_next;
    logic [BRT_W-1:0]        out_brt_reg, out_brt_next;
    logic [SLOT_W-1:0]       out_slot_reg, out_slot_next;

    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_upd;
    logic [BRT_W-1:0]        level_shown;
    logic [COLOR_W-1:0]      color_now;
    logic [TICK_W-1:0]       tick_plus;
    logic                    emit_ok;
    logic                    step_continue;

    tcfs_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign target = cfg.device_is_type_two ? cfg.brightness_type_two
                                           : cfg.brightness_type_one;

    tcfs_div #(
        .STEP_TICKS (STEP_TICKS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .brightness (target),
        .fade       (cfg.fade_ms),
        .done       (div_done),
        .quotient   (div_quot)
    );

    // level update with saturation to the signed accumulator range
    always_comb
    begin
        if (phase_reg == PH_FADE_IN)
            acc_sum = {acc_reg[ACC_W-1], acc_reg} + $signed({3'b000, step_reg});
        else
            acc_sum = {acc_reg[ACC_W-1], acc_reg} - $signed({3'b000, step_reg});
        if (acc_sum > ACC_MAX)
            acc_upd = ACC_MAX[ACC_W-1:0];
        else if (acc_sum < ACC_MIN)
            acc_upd = ACC_MIN[ACC_W-1:0];
        else
            acc_upd = acc_sum[ACC_W-1:0];
        if (acc_upd[ACC_W-1])
            level_shown = '0;
        else if (acc_upd[FRAC_W+BRT_W])
            level_shown = '1;
        else
            level_shown = acc_upd[FRAC_W+BRT_W-1:FRAC_W];
    end

    always_comb
    begin
        case (pos_reg)
            SLOT_SECOND: color_now = cfg.second_color;
            SLOT_LAST:   color_now = cfg.third_color;
            default:     color_now = cfg.first_color;
        endcase
    end

    assign tick_plus = tick_reg + 1'b1;
    assign emit_ok   = (cfg.fade_ms != '0) && (elapsed_reg < {1'b0, cfg.fade_ms});
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        tick_next      = tick_reg;
        elapsed_next   = elapsed_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        guard_next     = guard_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_color_next = out_color_reg;
        out_brt_next   = out_brt_reg;
        out_slot_next  = out_slot_reg;
        div_start      = 1'b0;
        step_continue  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    guard_next = '0;
                    if (!running || !active_reg)
                    begin
                        active_next  = running;
                        phase_next   = PH_FADE_IN;
                        pos_next     = SLOT_FIRST;
                        tick_next    = '0;
                        elapsed_next = '0;
                        acc_next     = '0;
                        step_next    = '0;
                    end
                    if (running)
                    begin
                        if (!active_reg && (cfg.fade_ms != '0))
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_STEP;
                        end
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    step_next  = div_quot;
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                if (phase_reg == PH_HOLD)
                begin
                    if (tick_reg < cfg.hold_ms)
                    begin
                        tick_next  = tick_plus;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        phase_next    = PH_FADE_OUT;
                        tick_next     = '0;
                        elapsed_next  = '0;
                        acc_next      = $signed({2'b00, target, {FRAC_W{1'b0}}});
                        step_continue = 1'b1;
                    end
                end
                else if (tick_reg != '0)
                begin
                    tick_next  = (tick_plus >= ST_TICK) ? '0 : tick_plus;
                    state_next = S_IDLE;
                end
                else if (emit_ok)
                begin
                    // hold the step while the previous word is still waiting
                    if (!out_valid_reg || out_ready)
                    begin
                        acc_next       = acc_upd;
                        elapsed_next   = elapsed_reg + ST_ELAPSE;
                        tick_next      = FIRST_TICK;
                        out_valid_next = 1'b1;
                        out_color_next = color_now;
                        out_brt_next   = level_shown;
                        out_slot_next  = pos_reg;
                        state_next     = S_IDLE;
                    end
                end
                else if (phase_reg == PH_FADE_IN)
                begin
                    phase_next    = PH_HOLD;
                    tick_next     = '0;
                    step_continue = 1'b1;
                end
                else
                begin
                    phase_next    = PH_FADE_IN;
                    pos_next      = (pos_reg == SLOT_LAST) ? SLOT_FIRST : pos_reg + 1'b1;
                    tick_next     = '0;
                    elapsed_next  = '0;
                    acc_next      = '0;
                    step_continue = 1'b1;
                end

                if (step_continue)
                begin
                    guard_next = guard_reg + 1'b1;
                    if (guard_reg == LAST_GUARD)
                        state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            phase_reg     <= PH_FADE_IN;
            pos_reg       <= SLOT_FIRST;
            tick_reg      <= '0;
            elapsed_reg   <= '0;
            acc_reg       <= '0;
            step_reg      <= '0;
            guard_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            tick_reg      <= tick_next;
            elapsed_reg   <= elapsed_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            guard_reg     <= guard_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_color_reg <= out_color_next;
        out_brt_reg   <= out_brt_next;
        out_slot_reg  <= out_slot_next;
    end

    assign out_valid        = out_valid_reg;
    assign shown_color      = out_color_reg;
    assign shown_brightness = out_brt_reg;
    assign color_slot       = out_slot_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (guard_reg <= LAST_GUARD))
        else $error("sequencer ran more than five steps in one tick");

    a_slot_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HOLD) |-> (tick_reg < ST_TICK))
        else $error("slot tick count out of range in a fade");

    a_idle_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (phase_reg == PH_FADE_IN && pos_reg == SLOT_FIRST
                         && acc_reg == '0))
        else $error("sequence state not cleared while idle");

    a_emit_only_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && out_valid_next) |-> (state_reg == S_STEP && emit_ok))
        else $error("output word loaded outside an emitting step");
`endif

endmodule

// ----- rtl/tcfs_regs.sv -----
// tcfs_regs: configuration register file, written through a plain write port
// depends on tcfs_pkg
module tcfs_regs
    import tcfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_COLOR:  cfg_next.first_color  = cfg_data[COLOR_W-1:0];
                REG_SECOND_COLOR: cfg_next.second_color = cfg_data[COLOR_W-1:0];
                REG_THIRD_COLOR:  cfg_next.third_color  = cfg_data[COLOR_W-1:0];
                REG_HOLD_MS:      cfg_next.hold_ms      = cfg_data[TICK_W-1:0];
                REG_FADE_MS:      cfg_next.fade_ms      = cfg_data[TICK_W-1:0];
                REG_BRT_ONE:      cfg_next.brightness_type_one = cfg_data[BRT_W-1:0];
                REG_BRT_TWO:      cfg_next.brightness_type_two = cfg_data[BRT_W-1:0];
                REG_TYPE_TWO:     cfg_next.device_is_type_two  = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_color         <= '0;
            cfg_reg.second_color        <= '0;
            cfg_reg.third_color         <= '0;
            cfg_reg.hold_ms             <= '0;
            cfg_reg.fade_ms             <= '0;
            cfg_reg.brightness_type_one <= BRT_RESET;
            cfg_reg.brightness_type_two <= BRT_RESET;
            cfg_reg.device_is_type_two  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/tcfs_div.sv -----
// tcfs_div: bit-serial restoring divider for the fade step,
// step = min(brightness * STEP_TICKS * 2^16 / fade, all ones), one bit a cycle
// depends on tcfs_pkg
module tcfs_div
    import tcfs_pkg::*;
#(
    parameter int STEP_TICKS = 50
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BRT_W-1:0]   brightness,
    input  logic [TICK_W-1:0]  fade,
    output logic               done,
    output logic [STEPV_W-1:0] quotient
);

    localparam int ST_W  = $clog2(STEP_TICKS + 1);
    localparam int PW    = BRT_W + ST_W;
    localparam int CNT_W = $clog2(STEPV_W + 1);
    localparam int LOW_W = STEPV_W - FRAC_W;

    logic [PW-1:0]      prod;
    logic [TICK_W-1:0]  high_part;
    logic [TICK_W:0]    trial;
    logic               trial_ge;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TICK_W-1:0]  rem_reg, rem_next;
    logic [STEPV_W-1:0] num_reg, num_next;
    logic [STEPV_W-1:0] quo_reg, quo_next;

    assign prod      = PW'(brightness) * PW'(STEP_TICKS);
    // dividend bits above the 24 quotient bits decide saturation
    assign high_part = TICK_W'(prod[PW-1:LOW_W]);
    assign trial     = {rem_reg, num_reg[STEPV_W-1]};
    assign trial_ge  = trial >= {1'b0, fade};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            if (high_part >= fade)
            begin
                quo_next  = '1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = high_part;
                num_next  = {prod[LOW_W-1:0], {FRAC_W{1'b0}}};
                quo_next  = '0;
                cnt_next  = CNT_W'(STEPV_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = trial_ge ? TICK_W'(trial - {1'b0, fade}) : trial[TICK_W-1:0];
            quo_next = {quo_reg[STEPV_W-2:0], trial_ge};
            num_next = {num_reg[STEPV_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
